// File: src/smre_pkg.sv
// ----------------------------------------------------------------------------
// Secure memory request expander package
// Shared types, address constants and address forming functions.
// ----------------------------------------------------------------------------
package smre_pkg;

    // Region bases of the protected memory layout.
    localparam logic [31:0] DATA_BASE = 32'h0800_0000;
    localparam logic [31:0] MAC_BASE  = 32'h0100_0000;
    localparam logic [31:0] CTR_BASE  = 32'h0020_0000;

    // Multiples of the data region span 939524097 that fit in 32 bits.
    localparam logic [31:0] SPAN_MULT [0:4] = '{
        32'd0, 32'd939524097, 32'd1879048194, 32'd2818572291, 32'd3758096388
    };

    // Integrity tree level bases; deeper levels reuse the last base.
    localparam logic [31:0] LEVEL_BASE [0:7] = '{
        32'd0, 32'd917504, 32'd974848, 32'd978432,
        32'd978656, 32'd978677, 32'd978677, 32'd978677
    };

    // Request source codes.
    localparam logic [2:0] SRC_PASS = 3'd0;
    localparam logic [2:0] SRC_DATA = 3'd1;
    localparam logic [2:0] SRC_MAC  = 3'd2;
    localparam logic [2:0] SRC_CTR  = 3'd3;
    localparam logic [2:0] SRC_TREE = 3'd4;

    // Sequencer step codes.
    localparam logic [1:0] STEP_HEAD = 2'd0;
    localparam logic [1:0] STEP_MAC  = 2'd1;
    localparam logic [1:0] STEP_CTR  = 2'd2;
    localparam logic [1:0] STEP_TREE = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_CACHE  = 1'b0;
    localparam logic CFG_ENGINE = 1'b1;

    typedef struct packed {
        logic [31:0] addr;
        logic        wr;
        logic        wt;
        logic [31:0] cyc;
    } t_item;

    typedef struct packed {
        logic [31:0] dram_address;
        logic [2:0]  source;
        logic [2:0]  tree_level;
        logic        write_flag;
        logic        weight_flag;
        logic [31:0] cycle_tag;
        logic        last;
    } t_result;

    // Data address: the address reduced modulo the span, then rebased.
    // The quotient is at most four, so all candidates are formed in parallel.
    function automatic logic [31:0] data_addr(input logic [31:0] a);
        logic [31:0] res;
        res = a + DATA_BASE;
        for (int k = 1; k < 5; k++) begin
            if (a >= SPAN_MULT[k]) begin
                res = a + (DATA_BASE - SPAN_MULT[k]);
            end
        end
        return res;
    endfunction

    // MAC address: block index divided by 8, offset modulo 8.
    function automatic logic [31:0] mac_addr(input logic [31:0] a);
        return {3'd0, a[31:17], 11'd0, a[2:0]} + MAC_BASE;
    endfunction

    // Counter address: block index divided by 4, offset modulo 4.
    function automatic logic [31:0] ctr_addr(input logic [31:0] a);
        return {2'd0, a[31:16], 12'd0, a[1:0]} + CTR_BASE;
    endfunction

    // Next tree node from the previous node address.
    function automatic logic [31:0] tree_addr(input logic [31:0] p, input logic [2:0] lvl);
        return {7'd0, p[31:21], 11'd0, p[6:4]} + LEVEL_BASE[lvl];
    endfunction

endpackage

// File: src/smre_addr_gen.sv
// ----------------------------------------------------------------------------
// Secure memory request expander address generator
// Forms the DRAM request for the current step of the held transaction.
// ----------------------------------------------------------------------------
module smre_addr_gen #(
    parameter int TREE_LEVELS = 6
) (
    input  smre_pkg::t_item   i_item,
    input  logic              i_cache,
    input  logic              i_engine,
    input  logic [1:0]        i_step,
    input  logic [2:0]        i_level,
    input  logic [31:0]       i_chain,
    output smre_pkg::t_result o_res
);
    import smre_pkg::*;

    localparam logic [2:0] LastLevel = 3'(TREE_LEVELS - 1);

    // Per step address, source and end of run flag.
    always_comb begin
        o_res.write_flag  = i_item.wr;
        o_res.weight_flag = i_item.wt;
        o_res.cycle_tag   = i_item.cyc;
        o_res.tree_level  = 3'd0;
        o_res.last        = 1'b0;
        unique case (i_step)
            STEP_HEAD: begin
                if (i_cache) begin
                    o_res.dram_address = i_item.addr;
                    o_res.source       = SRC_PASS;
                    o_res.last         = 1'b1;
                end else begin
                    o_res.dram_address = data_addr(i_item.addr);
                    o_res.source       = SRC_DATA;
                    o_res.last         = !i_engine;
                end
            end
            STEP_MAC: begin
                o_res.dram_address = mac_addr(i_item.addr);
                o_res.source       = SRC_MAC;
            end
            STEP_CTR: begin
                o_res.dram_address = ctr_addr(i_item.addr);
                o_res.source       = SRC_CTR;
            end
            default: begin
                o_res.dram_address = tree_addr(i_chain, i_level);
                o_res.source       = SRC_TREE;
                o_res.tree_level   = i_level;
                o_res.last         = (i_level == LastLevel);
            end
        endcase
    end

endmodule

// File: src/smre_seq.sv
// ----------------------------------------------------------------------------
// Secure memory request expander sequencer
// Holds one transaction and steps through its DRAM requests, one per unstalled cycle.
// ----------------------------------------------------------------------------
module smre_seq #(
    parameter int TREE_LEVELS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cache,
    input  logic              i_engine,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  smre_pkg::t_item   i_item,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output smre_pkg::t_result o_res
);
    import smre_pkg::*;

    localparam logic [2:0] LastLevel = 3'(TREE_LEVELS - 1);

    logic        r_busy, n_busy;
    logic [1:0]  r_step, n_step;
    logic [2:0]  r_level, n_level;
    logic [31:0] r_chain, n_chain;
    t_item       r_item;
    logic        r_cache, r_engine;
    logic        fire, done, accept;

    smre_addr_gen #(.TREE_LEVELS(TREE_LEVELS)) u_addr_gen (
        .i_item   (r_item),
        .i_cache  (r_cache),
        .i_engine (r_engine),
        .i_step   (r_step),
        .i_level  (r_level),
        .i_chain  (r_chain),
        .o_res    (o_res)
    );

    // Handshakes: a new transaction enters as the last request of the old one leaves.
    assign o_res_valid = r_busy;
    assign fire        = r_busy && i_res_ready;
    assign done        = fire && o_res.last;
    assign o_in_ready  = !r_busy || done;
    assign accept      = i_in_valid && o_in_ready;

    // Step sequencing.
    always_comb begin
        n_busy  = r_busy;
        n_step  = r_step;
        n_level = r_level;
        n_chain = r_chain;
        if (accept) begin
            n_busy  = 1'b1;
            n_step  = STEP_HEAD;
            n_level = 3'd0;
            n_chain = ctr_addr(i_item.addr);
        end else if (done) begin
            n_busy = 1'b0;
        end else if (fire) begin
            unique case (r_step)
                STEP_HEAD: n_step = STEP_MAC;
                STEP_MAC:  n_step = (r_item.wr && r_item.wt) ? STEP_TREE : STEP_CTR;
                STEP_CTR:  n_step = STEP_TREE;
                default: begin
                    n_level = r_level + 3'd1;
                    n_chain = o_res.dram_address;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= STEP_HEAD;
            r_level <= 3'd0;
        end else begin
            r_busy  <= n_busy;
            r_step  <= n_step;
            r_level <= n_level;
        end
    end

    // Transaction payload and tree chain.
    always_ff @(posedge i_clk) begin
        r_chain <= n_chain;
        if (accept) begin
            r_item   <= i_item;
            r_cache  <= i_cache;
            r_engine <= i_engine;
        end
    end

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == STEP_TREE) |-> (r_level <= LastLevel))
        else $error("tree level ran past the configured depth");

    a_meta_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step != STEP_HEAD) |-> (!r_cache && r_engine))
        else $error("metadata step outside engine mode");

    a_ctr_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == STEP_CTR) |-> !(r_item.wr && r_item.wt))
        else $error("counter request issued for a weight write");

    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && !i_in_valid) |=> !r_busy)
        else $error("sequencer stayed busy after the final request");

endmodule

// File: src/smre_out_stage.sv
// ----------------------------------------------------------------------------
// Secure memory request expander output stage
// Result register that holds a request until the receiver takes it.
// ----------------------------------------------------------------------------
module smre_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  smre_pkg::t_result i_res,
    output logic              o_valid,
    input  logic              i_ready,
    output smre_pkg::t_result o_res
);
    import smre_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    load;

    // The register refills in the cycle it is emptied.
    assign o_in_ready = !r_valid || i_ready;
    assign load       = i_in_valid && o_in_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: src/secure_memory_request_expander_core.sv
// ----------------------------------------------------------------------------
// Secure memory request expander
// Expands memory requests into data, MAC, counter and integrity tree
// requests for a memory encryption engine.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on the input channel (i_valid / o_ready) and leaves as a
// run of DRAM requests on the output channel (o_valid / i_ready), the final
// one marked by o_last. In cache mode the run is one passthrough request;
// with the cache path off it is one data request, or with the engine on a
// data, MAC, optional counter and TREE_LEVELS tree requests.
// The first request of a run passes through the sequencer's transaction
// registers and then the output register before the receiver can take it.
// The sequencer emits one request per cycle while the output register can
// accept it, so a transaction holds the block until its whole run has
// left; weight writes skip the counter request. The next transaction is
// accepted in the cycle the last request of the current run moves to the
// output register.
// When the receiver stalls, the output register holds its request and the
// sequencer and input channel stall behind it; nothing is dropped.
// Reset clears all pending requests and sets both configuration bits to 1.
// Configuration writes (i_cfg_wr_en) take effect for the next transaction.
// ----------------------------------------------------------------------------
module secure_memory_request_expander_core #(
    parameter int TREE_LEVELS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_request_address,
    input  logic        i_is_write,
    input  logic        i_is_weight,
    input  logic [31:0] i_issue_cycle,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_dram_address,
    output logic [2:0]  o_source,
    output logic [2:0]  o_tree_level,
    output logic        o_write_flag,
    output logic        o_weight_flag,
    output logic [31:0] o_cycle_tag,
    output logic        o_last
);
    import smre_pkg::*;

    logic    r_cache_en, r_engine_en;
    t_item   in_item;
    t_result seq_res, out_res;
    logic    seq_valid, seq_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_en  <= 1'b1;
            r_engine_en <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CACHE:  r_cache_en  <= i_cfg_data;
                CFG_ENGINE: r_engine_en <= i_cfg_data;
                default:    r_cache_en  <= r_cache_en;
            endcase
        end
    end

    assign in_item = '{addr: i_request_address, wr: i_is_write,
                       wt: i_is_weight, cyc: i_issue_cycle};

    smre_seq #(.TREE_LEVELS(TREE_LEVELS)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cache     (r_cache_en),
        .i_engine    (r_engine_en),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_item      (in_item),
        .o_res_valid (seq_valid),
        .i_res_ready (seq_ready),
        .o_res       (seq_res)
    );

    smre_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (seq_valid),
        .o_in_ready (seq_ready),
        .i_res      (seq_res),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    assign o_dram_address = out_res.dram_address;
    assign o_source       = out_res.source;
    assign o_tree_level   = out_res.tree_level;
    assign o_write_flag   = out_res.write_flag;
    assign o_weight_flag  = out_res.weight_flag;
    assign o_cycle_tag    = out_res.cycle_tag;
    assign o_last         = out_res.last;

endmodule

// File: tb/tb_secure_memory_request_expander_core.sv
// ----------------------------------------------------------------------------
// Secure memory request expander testbench
// Sends memory requests through the expander under every combination of the
// cache path and engine settings. A local model predicts each run of DRAM
// requests. Each DRAM request is checked field by field against the oldest
// prediction. Random sender gaps and receiver stalls, a long receiver
// hold-off and a full drain pause exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_secure_memory_request_expander_core;
    import smre_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LEVELS      = 6;
    localparam logic [31:0] DATA_SPAN   = 32'd939524097;
    localparam int          STUCK_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN_WAIT  = 4;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_index;
    logic        i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_request_address;
    logic        i_is_write;
    logic        i_is_weight;
    logic [31:0] i_issue_cycle;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_dram_address;
    logic [2:0]  o_source;
    logic [2:0]  o_tree_level;
    logic        o_write_flag;
    logic        o_weight_flag;
    logic [31:0] o_cycle_tag;
    logic        o_last;

    // Local copy of the configuration registers.
    logic        cache_en;
    logic        engine_en;

    t_result     pending_dram_q[$];
    int          requests_sent;
    int          dram_checked;
    int          mismatch_count;
    int          stuck_cycles;
    int          burst_left;
    bit          gaps_on;
    rx_mode_e    rx_mode;
    int          hold_request;

    secure_memory_request_expander_core #(
        .TREE_LEVELS(LEVELS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_request_address (i_request_address),
        .i_is_write        (i_is_write),
        .i_is_weight       (i_is_weight),
        .i_issue_cycle     (i_issue_cycle),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_dram_address    (o_dram_address),
        .o_source          (o_source),
        .o_tree_level      (o_tree_level),
        .o_write_flag      (o_write_flag),
        .o_weight_flag     (o_weight_flag),
        .o_cycle_tag       (o_cycle_tag),
        .o_last            (o_last)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Block address in the upper 18 bits, offset in the lower 14 bits.
    function automatic logic [31:0] compose(input logic [31:0] block,
                                            input logic [31:0] offset);
        return ((block & 32'h3FFFF) << 14) | (offset & 32'h3FFF);
    endfunction

    // Works out the run of DRAM requests for one accepted memory request.
    function automatic void expand_request(input t_item req);
        t_result     run [0:8];
        t_result     r;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] ctr;
        logic [31:0] node;
        int          n;
        n = 0;
        r = '0;
        r.write_flag  = req.wr;
        r.weight_flag = req.wt;
        r.cycle_tag   = req.cyc;
        if (cache_en) begin
            r.dram_address = req.addr;
            r.source       = SRC_PASS;
            run[n]         = r;
            n++;
        end else begin
            r.dram_address = req.addr % DATA_SPAN + DATA_BASE;
            r.source       = SRC_DATA;
            run[n]         = r;
            n++;
            if (engine_en) begin
                lo  = req.addr & 32'h3FFF;
                hi  = req.addr >> 14;
                ctr = compose(hi >> 2, lo & 32'd3) + CTR_BASE;
                r.dram_address = compose(hi >> 3, lo & 32'd7) + MAC_BASE;
                r.source       = SRC_MAC;
                run[n]         = r;
                n++;
                // Weight writes skip the counter fetch but still walk the tree.
                if (!(req.wr && req.wt)) begin
                    r.dram_address = ctr;
                    r.source       = SRC_CTR;
                    run[n]         = r;
                    n++;
                end
                node = ctr;
                for (int k = 0; k < LEVELS; k++) begin
                    node = compose((node >> 14) >> 7, ((node & 32'h3FFF) >> 4) & 32'd7)
                           + LEVEL_BASE[(k > 7) ? 7 : k];
                    r.dram_address = node;
                    r.source       = SRC_TREE;
                    r.tree_level   = 3'(k);
                    run[n]         = r;
                    n++;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            run[i].last = (i == n - 1);
            pending_dram_q = {pending_dram_q, run[i]};
        end
    endfunction

    function automatic t_item make_request(input logic [31:0] addr, input logic wr,
                                           input logic wt, input logic [31:0] cyc);
        t_item it;
        it.addr = addr;
        it.wr   = wr;
        it.wt   = wt;
        it.cyc  = cyc;
        return it;
    endfunction

    // Random request; addresses cluster near span multiples, zero and the top.
    function automatic t_item random_request();
        logic [31:0] addr;
        case ($urandom_range(0, 3))
            0: addr = $urandom;
            1: addr = DATA_SPAN * $urandom_range(1, 4) + $urandom_range(0, 4) - 2;
            2: addr = $urandom_range(0, 65535);
            default: addr = 32'hFFFF_FFFF - $urandom_range(0, 65535);
        endcase
        return make_request(addr, 1'($urandom), 1'($urandom), $urandom);
    endfunction

    // Offers one request, with optional random gaps between bursts, and waits for it.
    task automatic send_request(input t_item req);
        int gap;
        if (burst_left == 0) begin
            if (gaps_on) begin
                gap = $urandom_range(0, 6);
                if ($urandom_range(0, 7) == 0) gap = $urandom_range(7, 25);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid           <= 1'b1;
        i_request_address <= req.addr;
        i_is_write        <= req.wr;
        i_is_weight       <= req.wt;
        i_issue_cycle     <= req.cyc;
        do @(posedge i_clk); while (!o_ready);
        expand_request(req);
        requests_sent++;
    endtask

    // Stops offering and waits until every predicted request has arrived.
    task automatic drain_requests();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_dram_q.size() != 0) @(posedge i_clk);
    endtask

    // Register writes happen only once the block has gone idle.
    task automatic write_config(input logic idx, input logic val);
        drain_requests();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_CACHE) cache_en = val;
        else engine_en = val;
    endtask

    task automatic set_mode(input logic cache, input logic engine);
        write_config(CFG_CACHE, cache);
        write_config(CFG_ENGINE, engine);
    endtask

    // After reset both registers are set, so requests pass straight through.
    task automatic test_reset_defaults();
        send_request(make_request(32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000));
        send_request(make_request(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_request(make_request(32'hA5A5_5A5A, 1'b1, 1'b0, 32'h5A5A_A5A5));
    endtask

    // With the cache path on, the engine setting has no effect.
    task automatic test_cache_path();
        set_mode(1'b1, 1'b0);
        send_request(make_request(32'h1234_5678, 1'b0, 1'b1, 32'h0000_0001));
        send_request(make_request(32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000));
    endtask

    // Data-only mode: the modulo reduction around each span multiple.
    task automatic test_data_region();
        set_mode(1'b0, 1'b0);
        send_request(make_request(32'd0, 1'b0, 1'b0, 32'd10));
        send_request(make_request(DATA_SPAN - 1, 1'b1, 1'b0, 32'd11));
        send_request(make_request(DATA_SPAN, 1'b0, 1'b1, 32'd12));
        send_request(make_request(DATA_SPAN * 2 - 1, 1'b1, 1'b1, 32'd13));
        send_request(make_request(DATA_SPAN * 3, 1'b0, 1'b0, 32'd14));
        send_request(make_request(DATA_SPAN * 4 - 1, 1'b0, 1'b0, 32'd15));
        send_request(make_request(DATA_SPAN * 4, 1'b1, 1'b0, 32'd16));
        send_request(make_request(32'hFFFF_FFFF, 1'b0, 1'b1, 32'd17));
    endtask

    // Full metadata runs, including the weight write that skips the counter.
    task automatic test_engine_metadata();
        set_mode(1'b0, 1'b1);
        send_request(make_request(32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000));
        send_request(make_request(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_request(make_request(32'h0000_3FFF, 1'b1, 1'b0, 32'h0000_0100));
        send_request(make_request(32'hFFFF_C000, 1'b0, 1'b1, 32'h0000_0200));
        send_request(make_request(32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0300));
        send_request(make_request(32'h0000_0000, 1'b1, 1'b1, 32'h0000_0400));
        send_request(make_request(32'h8000_0000, 1'b1, 1'b1, 32'h0000_0500));
        send_request(make_request(32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0000_0600));
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (24) send_request(random_request());
        gaps_on = 1'b1;
    endtask

    // The sender stops until the block has fully drained, then resumes.
    task automatic test_sender_drain();
        repeat (10) send_request(random_request());
        drain_requests();
        repeat (10) send_request(random_request());
    endtask

    // Random traffic in phases; the first four cover every mode.
    task automatic test_random_traffic();
        logic cache;
        logic engine;
        for (int phase = 0; phase < 10; phase++) begin
            if (phase < 4) begin
                cache  = phase[1];
                engine = phase[0];
            end else begin
                cache  = ($urandom_range(0, 3) == 0);
                engine = ($urandom_range(0, 3) != 0);
            end
            set_mode(cache, engine);
            rx_mode = rx_mode_e'($urandom_range(0, 2));
            gaps_on = (phase % 3 != 2);
            repeat (46) send_request(random_request());
        end
        rx_mode = RX_RANDOM;
        gaps_on = 1'b1;
    endtask

    // Receiver stalls follow the current mode, or a requested long hold-off.
    initial begin
        int hold_left;
        int rx_tick;
        hold_left = 0;
        rx_tick   = 0;
        i_ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            rx_tick++;
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  i_ready <= 1'b1;
                    RX_RANDOM:  i_ready <= ($urandom_range(0, 2) != 0);
                    default:    i_ready <= ((rx_tick % 11) > 3);
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Each output transaction is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_output
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_dram_q.size() == 0) begin
                $error("unexpected DRAM request at address 0x%08h", o_dram_address);
                mismatch_count++;
            end else begin
                want = pending_dram_q.pop_front();
                check_field("dram_address", want.dram_address, o_dram_address);
                check_field("source", 32'(want.source), 32'(o_source));
                check_field("tree_level", 32'(want.tree_level), 32'(o_tree_level));
                check_field("write_flag", 32'(want.write_flag), 32'(o_write_flag));
                check_field("weight_flag", 32'(want.weight_flag), 32'(o_weight_flag));
                check_field("cycle_tag", want.cycle_tag, o_cycle_tag);
                check_field("last", 32'(want.last), 32'(o_last));
                dram_checked++;
            end
        end
    end

    // Ends the run when no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("secure_memory_request_expander_core test failed");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_index       = 1'b0;
        i_cfg_data        = 1'b0;
        i_valid           = 1'b0;
        i_request_address = '0;
        i_is_write        = 1'b0;
        i_is_weight       = 1'b0;
        i_issue_cycle     = '0;
        cache_en          = 1'b1;
        engine_en         = 1'b1;
        requests_sent     = 0;
        dram_checked      = 0;
        mismatch_count    = 0;
        stuck_cycles      = 0;
        burst_left        = 0;
        gaps_on           = 1'b1;
        rx_mode           = RX_RANDOM;
        hold_request      = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_cache_path();
        test_data_region();
        test_engine_metadata();
        test_output_backpressure();
        test_sender_drain();
        test_random_traffic();

        drain_requests();
        repeat (20) @(posedge i_clk);
        if (pending_dram_q.size() != 0) begin
            $error("%0d predicted DRAM requests never arrived", pending_dram_q.size());
            mismatch_count++;
        end
        $display("Sent %0d memory requests over all cache and engine modes,", requests_sent);
        $display("checked %0d DRAM requests with sender gaps and receiver stalls.",
                 dram_checked);
        if (mismatch_count == 0) begin
            $display("secure_memory_request_expander_core test passed");
        end else begin
            $display("secure_memory_request_expander_core test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
src/smre_pkg.sv
src/smre_addr_gen.sv
src/smre_seq.sv
src/smre_out_stage.sv
src/secure_memory_request_expander_core.sv
tb/tb_secure_memory_request_expander_core.sv
